// ===== rtl/nnsc_pkg.sv =====
// package for the node name syntax check unit: payload types, state type and constants
`default_nettype none

package nnsc_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned LEN_W      = 8;
   localparam int unsigned PARTS_W    = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CHAR_W-1:0]  CASE_OFFSET = 8'h20;
   localparam logic [CHAR_W-1:0]  CHAR_DOT    = 8'h2e;
   localparam logic [CHAR_W-1:0]  CHAR_DASH   = 8'h2d;
   localparam logic [CHAR_W-1:0]  CHAR_UNDER  = 8'h5f;
   localparam logic [CHAR_W-1:0]  CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_UP_Z   = 8'h5a;
   localparam logic [CHAR_W-1:0]  CHAR_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_LOW_Z  = 8'h7a;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE   = 8'h39;

   localparam logic [LEN_W-1:0]   LEN_MAX     = 8'hff;
   localparam logic [PARTS_W-1:0] PARTS_MAX   = 4'hf;

   localparam logic [LEN_W-1:0]   RST_MAX_NAME_LEN = 8'd50;
   localparam logic [LEN_W-1:0]   RST_MAX_PART_LEN = 8'd16;
   localparam logic [PARTS_W-1:0] RST_MAX_PARTS    = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_NAME_LEN = 2'd0,
      CSR_MAX_PART_LEN = 2'd1,
      CSR_MAX_PARTS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_SYNTAX   = 2'd2
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              last_char;
      logic              empty_name;
   } req_data_type;

   typedef struct packed {
      logic [CHAR_W-1:0] lower_char;
      logic              name_done;
      logic [1:0]        status;
   } rsp_data_type;

   typedef struct packed {
      logic [LEN_W-1:0]  max_name_len;
      logic [LEN_W-1:0]  max_part_len;
      logic [PARTS_W-1:0] max_parts;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]   byte_count;
      logic [LEN_W-1:0]   part_length;
      logic [PARTS_W-1:0] part_count;
      logic               at_part_start;
      logic               syntax_bad;
      logic               too_long;
   } name_state_type;

   localparam name_state_type NAME_STATE_CLEAR = '{
      byte_count:    '0,
      part_length:   '0,
      part_count:    4'd1,
      at_part_start: 1'b1,
      syntax_bad:    1'b0,
      too_long:      1'b0
   };

endpackage

`default_nettype wire

// ===== rtl/nnsc_parse.sv =====
// per-byte parse step: case fold, limit checks and next name state
`default_nettype none

module nnsc_parse
   import nnsc_pkg::*;
(
   input  wire  req_data_type   item,
   input  wire  name_state_type state_cur,
   input  wire  cfg_type        cfg,
   output name_state_type       state_next,
   output rsp_data_type         result
);

   logic [CHAR_W-1:0] lc;
   logic              is_letter;
   logic              is_body;
   logic              part_full;
   logic [LEN_W-1:0]  part_len_inc;
   name_state_type    st;

   always_comb begin
      lc = item.char_in;
      if (item.char_in >= CHAR_UP_A && item.char_in <= CHAR_UP_Z) begin
         lc = item.char_in + CASE_OFFSET;
      end
   end

   assign is_letter    = (lc >= CHAR_LOW_A) && (lc <= CHAR_LOW_Z);
   assign is_body      = is_letter || ((lc >= CHAR_ZERO) && (lc <= CHAR_NINE))
                         || (lc == CHAR_DASH) || (lc == CHAR_UNDER);
   assign part_full    = state_cur.part_length >= cfg.max_part_len;
   assign part_len_inc = (state_cur.part_length == LEN_MAX) ? LEN_MAX
                         : state_cur.part_length + 8'd1;

   always_comb begin
      st = state_cur;
      if (state_cur.byte_count >= cfg.max_name_len) begin
         st.too_long = 1'b1;
      end
      if (state_cur.byte_count != LEN_MAX) begin
         st.byte_count = state_cur.byte_count + 8'd1;
      end

      if (state_cur.at_part_start) begin
         if (!is_letter || part_full) begin
            st.syntax_bad = 1'b1;
         end
         st.at_part_start = 1'b0;
         st.part_length   = part_len_inc;
      end else if (lc == CHAR_DOT) begin
         if (state_cur.part_count >= cfg.max_parts) begin
            st.syntax_bad = 1'b1;
         end
         if (state_cur.part_count != PARTS_MAX) begin
            st.part_count = state_cur.part_count + 4'd1;
         end
         st.part_length   = '0;
         st.at_part_start = 1'b1;
      end else begin
         if (!is_body || part_full) begin
            st.syntax_bad = 1'b1;
         end
         st.part_length = part_len_inc;
      end
      // a name that ends right after a dot has an empty last part
      if (item.last_char && st.at_part_start) begin
         st.syntax_bad = 1'b1;
      end
   end

   always_comb begin
      result.lower_char = lc;
      result.name_done  = 1'b0;
      result.status     = STATUS_VALID;
      state_next        = st;
      if (item.empty_name) begin
         result.lower_char = '0;
         result.name_done  = 1'b1;
         state_next        = NAME_STATE_CLEAR;
      end else if (item.last_char) begin
         result.name_done = 1'b1;
         if (st.too_long) begin
            result.status = STATUS_TOO_LONG;
         end else if (st.syntax_bad) begin
            result.status = STATUS_SYNTAX;
         end
         state_next = NAME_STATE_CLEAR;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/node_name_syntax_check_unit.sv =====
// top level of the node name syntax check unit
`default_nettype none

// node name checker, one byte per transaction. each byte comes back folded
// to lower case; the transaction carrying last_char also reports the name's
// final status (valid, too long, syntax error), and an empty_name
// transaction reports valid at once. one transaction is taken per cycle
// unless a stalled result holds up the input register; each byte passes
// through the input register, then sits in the result register until
// the result side takes it. the name state (byte, part and part-count
// counters, flags) is updated in the same cycle a byte
// moves from the input register to the result register, so consecutive
// bytes of one name go through at full rate. the limits in the csr
// registers must only be changed while no transaction is in flight.
module node_name_syntax_check_unit
   import nnsc_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  req_data_type    req_data,
   // result channel
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output rsp_data_type          rsp_data,
   // configuration writes
   input  wire                   csr_write,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata
);

   // limit registers
   cfg_type        cfg_ff;
   cfg_type        cfg_in;

   // input register stage
   logic           in_valid_ff;
   logic           in_valid_in;
   req_data_type   in_data_ff;

   // result register stage
   logic           out_valid_ff;
   logic           out_valid_in;
   rsp_data_type   out_data_ff;

   // per-name parse state
   name_state_type state_ff;
   name_state_type state_in;

   rsp_data_type   parse_result;
   logic           advance;
   logic           take_req;

   // input stage moves forward when the result register is empty or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // input register frees up when empty or when its byte moves on
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   nnsc_parse u_parse (
      .item       (in_data_ff),
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (parse_result)
   );

   // register writes, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_NAME_LEN: cfg_in.max_name_len = csr_wdata;
            CSR_MAX_PART_LEN: cfg_in.max_part_len = csr_wdata;
            CSR_MAX_PARTS:    cfg_in.max_parts    = csr_wdata[PARTS_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_name_len <= RST_MAX_NAME_LEN;
         cfg_ff.max_part_len <= RST_MAX_PART_LEN;
         cfg_ff.max_parts    <= RST_MAX_PARTS;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         state_ff            <= NAME_STATE_CLEAR;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= parse_result;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nnsc_checker.sv =====
// port-level checker for the node name syntax check unit and its bind
`default_nettype none

module nnsc_checker
   import nnsc_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire  req_data_type    req_data,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire  rsp_data_type    rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // requests back up only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while result side is free");

   // a non-valid status only comes with the end of a name
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_VALID) |-> rsp_data.name_done)
      else $error("error status before end of name");

endmodule

bind node_name_syntax_check_unit nnsc_checker u_nnsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the node name syntax check unit: directed vectors, random names, scoreboard

module tb;
   import nnsc_pkg::*;

   // spare register slot, writes to it must have no effect
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // request register plus result register
   localparam int LATENCY = 2;

   // one row of the directed table; has_want marks a result typed in by hand
   typedef struct {
      req_data_type d;
      bit           has_want;
      rsp_data_type want;
   } name_vector_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_data_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // hand-typed expectation travels with the transaction it belongs to
   bit                    req_has_want = 1'b0;
   rsp_data_type          req_want = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int sent_count = 0;
   int fail_count = 0;

   // predictor copy of the limit registers and the per-name state
   cfg_type limits = '{
      max_name_len: RST_MAX_NAME_LEN,
      max_part_len: RST_MAX_PART_LEN,
      max_parts:    RST_MAX_PARTS
   };
   name_state_type name_st = NAME_STATE_CLEAR;

   // folded bytes and status still owed by the unit, oldest first
   rsp_data_type pending_results[$];
   // bytes of the name being built by the random generator
   logic [7:0] name_buf[$];
   name_vector_type vectors[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   node_name_syntax_check_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_letter(logic [7:0] c);
      return c >= CHAR_LOW_A && c <= CHAR_LOW_Z;
   endfunction

   // one more byte in the current part, checked against the part limit first
   function automatic void count_part_byte();
      if (name_st.part_length >= limits.max_part_len) name_st.syntax_bad = 1'b1;
      if (name_st.part_length != LEN_MAX) name_st.part_length = name_st.part_length + 1'b1;
   endfunction

   function automatic rsp_data_type fold_name_byte(req_data_type r);
      rsp_data_type res;
      logic [7:0]   lc;
      res = '0;
      // empty name: report valid at once and drop anything under way
      if (r.empty_name) begin
         name_st = NAME_STATE_CLEAR;
         res.name_done = 1'b1;
         res.status = STATUS_VALID;
         return res;
      end
      lc = (r.char_in >= CHAR_UP_A && r.char_in <= CHAR_UP_Z) ? r.char_in + CASE_OFFSET
                                                               : r.char_in;
      // length limit checked before the saturating count moves
      if (name_st.byte_count >= limits.max_name_len) name_st.too_long = 1'b1;
      if (name_st.byte_count != LEN_MAX) name_st.byte_count = name_st.byte_count + 1'b1;
      if (name_st.at_part_start) begin
         // first byte of a part must be a letter, a dot here means an empty part
         if (!is_letter(lc)) name_st.syntax_bad = 1'b1;
         name_st.at_part_start = 1'b0;
         count_part_byte();
      end else if (lc == CHAR_DOT) begin
         if (name_st.part_count >= limits.max_parts) name_st.syntax_bad = 1'b1;
         if (name_st.part_count != PARTS_MAX) name_st.part_count = name_st.part_count + 1'b1;
         name_st.part_length = '0;
         name_st.at_part_start = 1'b1;
      end else begin
         if (!(is_letter(lc) || (lc >= CHAR_ZERO && lc <= CHAR_NINE) ||
               lc == CHAR_DASH || lc == CHAR_UNDER))
            name_st.syntax_bad = 1'b1;
         count_part_byte();
      end
      res.lower_char = lc;
      if (r.last_char) begin
         // name ending right after a dot leaves an empty last part
         if (name_st.at_part_start) name_st.syntax_bad = 1'b1;
         res.name_done = 1'b1;
         res.status = name_st.too_long ? STATUS_TOO_LONG :
                      (name_st.syntax_bad ? STATUS_SYNTAX : STATUS_VALID);
         name_st = NAME_STATE_CLEAR;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- scoreboard

   task automatic report_mismatch(string what, int got, int want_v);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want_v);
      fail_count++;
   endtask

   // both channels sampled at the edge, before any of this edge's updates land
   always @(posedge clock) begin : scoreboard
      rsp_data_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // predictor state always advances, even for hand-typed rows
            want = fold_name_byte(req_data);
            pending_results.push_back(req_has_want ? req_want : want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_data), 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.lower_char !== want.lower_char)
                  report_mismatch("lower_char", int'(rsp_data.lower_char),
                                  int'(want.lower_char));
               if (rsp_data.name_done !== want.name_done)
                  report_mismatch("name_done", int'(rsp_data.name_done),
                                  int'(want.name_done));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", int'(rsp_data.status), int'(want.status));
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // present one transaction and hold it until the unit takes it
   task automatic send_item(req_data_type d, bit has_want, rsp_data_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      req_has_want <= has_want;
      req_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // stop sending and wait for every owed result, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // csr_write stays high across back-to-back writes, caller lowers it
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MAX_NAME_LEN: limits.max_name_len = val;
         CSR_MAX_PART_LEN: limits.max_part_len = val;
         CSR_MAX_PARTS:    limits.max_parts = val[PARTS_W-1:0];
         default: ;
      endcase
   endtask

   // all three limits plus a write to the spare slot; upper bits of the
   // part count register get junk, the unit must drop them
   task automatic program_limits(logic [7:0] name_len, logic [7:0] seg_limit,
                                 logic [3:0] parts);
      logic [3:0] junk;
      logic [7:0] spare_val;
      junk = 4'($urandom_range(15));
      spare_val = 8'($urandom_range(255));
      write_csr(CSR_SPARE, spare_val);
      write_csr(CSR_MAX_NAME_LEN, name_len);
      write_csr(CSR_MAX_PART_LEN, seg_limit);
      write_csr(CSR_MAX_PARTS, {junk, parts});
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] rand_letter();
      return 8'(($urandom_range(1) ? CHAR_UP_A : CHAR_LOW_A) + $urandom_range(25));
   endfunction

   // directed row with its result typed in
   function automatic name_vector_type fixed_row(logic [7:0] c, bit last, bit empty,
                                                 logic [7:0] lc, status_type st);
      name_vector_type v;
      v.d = '{char_in: c, last_char: last, empty_name: empty};
      v.has_want = 1'b1;
      v.want = '{lower_char: lc, name_done: 1'b1, status: st};
      return v;
   endfunction

   // directed row left to the predictor
   function automatic name_vector_type open_row(logic [7:0] c, bit last);
      name_vector_type v;
      v.d = '{char_in: c, last_char: last, empty_name: 1'b0};
      v.has_want = 1'b0;
      v.want = '0;
      return v;
   endfunction

   // mostly well-formed names sized around the current limits, some broken
   // on purpose, some abandoned with an empty-name marker, some pure noise
   task automatic send_random_name();
      int kind, n_parts, seg_len, len_cap, i, j;
      bit abandon;
      req_data_type d;
      kind = $urandom_range(99);
      if (kind < 8) begin
         d = req_data_type'(10'($urandom_range(1023)));
         send_item(d, 1'b0, '0);
         return;
      end
      name_buf.delete();
      n_parts = $urandom_range(1, (limits.max_parts < 4) ? limits.max_parts + 1 : 5);
      // a few names carry long parts to reach the length limits
      len_cap = (kind < 18) ? 20 : 8;
      for (i = 0; i < n_parts; i++) begin
         if (i != 0) name_buf.push_back(CHAR_DOT);
         seg_len = $urandom_range(1, (limits.max_part_len < len_cap) ?
                                     limits.max_part_len + 1 : len_cap);
         name_buf.push_back(rand_letter());
         for (j = 1; j < seg_len; j++) begin
            case ($urandom_range(4))
               0, 1:    name_buf.push_back(rand_letter());
               2:       name_buf.push_back(8'(CHAR_ZERO + $urandom_range(9)));
               3:       name_buf.push_back(CHAR_DASH);
               default: name_buf.push_back(CHAR_UNDER);
            endcase
         end
      end
      if (kind >= 18 && kind < 30)
         // any byte value anywhere in the name
         name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(255));
      else if (kind >= 30 && kind < 36)
         // name ends on a dot
         name_buf.push_back(CHAR_DOT);
      else if (kind >= 36 && kind < 42)
         // a dot put in anywhere: leading dot, two dots in a row or a split part
         name_buf.insert($urandom_range(name_buf.size() - 1), CHAR_DOT);
      abandon = (kind >= 42 && kind < 48);
      for (i = 0; i < name_buf.size(); i++) begin
         d.char_in = name_buf[i];
         d.last_char = (i == name_buf.size() - 1);
         d.empty_name = 1'b0;
         if (abandon && d.last_char) begin
            // empty-name marker in place of the last byte drops the name
            d.empty_name = 1'b1;
            d.last_char = 1'($urandom_range(1));
         end
         send_item(d, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main
      int ph, budget, i;
      bit held;
      req_data_type d;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset limits (50 bytes, 16 per part, 3 parts)
      vectors = '{
         fixed_row(8'hff, 1'b0, 1'b1, 8'h00, STATUS_VALID),   // empty name
         fixed_row(8'h41, 1'b1, 1'b0, 8'h61, STATUS_VALID),   // "A"
         fixed_row(8'h5a, 1'b1, 1'b0, 8'h7a, STATUS_VALID),   // "Z"
         fixed_row(8'h30, 1'b1, 1'b0, 8'h30, STATUS_SYNTAX),  // starts with digit
         fixed_row(8'h00, 1'b1, 1'b0, 8'h00, STATUS_SYNTAX),  // lowest byte
         fixed_row(8'hff, 1'b1, 1'b0, 8'hff, STATUS_SYNTAX),  // highest byte
         fixed_row(8'h2e, 1'b1, 1'b0, 8'h2e, STATUS_SYNTAX),  // lone dot
         // "x.Y-_9.m": three parts, every body class
         open_row(8'h78, 1'b0),
         open_row(8'h2e, 1'b0),
         open_row(8'h59, 1'b0),
         open_row(8'h2d, 1'b0),
         open_row(8'h5f, 1'b0),
         open_row(8'h39, 1'b0),
         open_row(8'h2e, 1'b0),
         open_row(8'h6d, 1'b1),
         // "a@" then dropped by an empty name in mid-stream
         open_row(8'h61, 1'b0),
         open_row(8'h40, 1'b0),
         fixed_row(8'h6b, 1'b0, 1'b1, 8'h00, STATUS_VALID),
         // "b[": bad body byte just past the upper-case range
         open_row(8'h62, 1'b0),
         open_row(8'h5b, 1'b1),
         // "c.": ends right after a dot
         open_row(8'h63, 1'b0),
         fixed_row(8'h2e, 1'b1, 1'b0, 8'h2e, STATUS_SYNTAX),
         fixed_row(8'h60, 1'b1, 1'b0, 8'h60, STATUS_SYNTAX),  // just below 'a'
         fixed_row(8'h7b, 1'b1, 1'b0, 8'h7b, STATUS_SYNTAX),  // just above 'z'
         fixed_row(8'h61, 1'b1, 1'b1, 8'h00, STATUS_VALID)    // empty wins over last
      };
      set_idling(18, 77);
      foreach (vectors[k]) send_item(vectors[k].d, vectors[k].has_want, vectors[k].want);
      settle();

      // random part: six limit settings, idling pattern changes every two
      for (ph = 0; ph < 6; ph++) begin
         if (ph == 2) set_idling(77, 18);
         if (ph == 4) set_idling(0, 0);
         case (ph)
            0: program_limits(8'd255, 8'd255, 4'd15);
            1: program_limits(8'd1, 8'd1, 4'd1);
            2: program_limits(8'd0, 8'd0, 4'd0);
            3: program_limits(8'd12, 8'd4, 4'd3);
            4: program_limits(8'd20, 8'd6, 4'd5);
            default: program_limits(8'($urandom_range(1, 40)), 8'($urandom_range(1, 10)),
                                     4'($urandom_range(1, 6)));
         endcase
         budget = sent_count + 40;
         held = 1'b0;
         while (sent_count < budget) begin
            send_random_name();
            // halfway through, hold off until the unit has caught up
            if (!held && sent_count >= budget - 20) begin
               settle();
               held = 1'b1;
            end
         end
         if (ph == 0) begin
            // one single-part name past 255 bytes: counters saturate, both limits hit
            for (i = 0; i < 258; i++) begin
               d = '{char_in: rand_letter(), last_char: (i == 257), empty_name: 1'b0};
               send_item(d, 1'b0, '0);
            end
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("PASS node_name_syntax_check_unit");
      end else begin
         $display("FAIL node_name_syntax_check_unit");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("FAIL node_name_syntax_check_unit");
      $finish;
   end

endmodule
